[rtl/core/pit_pkg.sv]
package pit_pkg;

  // Command codes of an input beat
  typedef enum logic [2:0] {
    CMD_DEFINE     = 3'd0,
    CMD_CHECK      = 3'd1,
    CMD_INVAL      = 3'd2,
    CMD_CHECK_INV  = 3'd3,
    CMD_INVAL_BLK  = 3'd4,
    CMD_COPY_BLK   = 3'd5,
    CMD_MOVE_BLK   = 3'd6,
    CMD_RESERVED   = 3'd7
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_MISALIGNED = 3'd1,
    STS_MISSING    = 3'd2,
    STS_MISMATCH   = 3'd3,
    STS_OVERFLOW   = 3'd4,
    STS_OVERLAP    = 3'd5,
    STS_FULL       = 3'd6,
    STS_UNKNOWN    = 3'd7
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_EVAL,
    S_SCAN,
    S_FIN,
    S_CP_RD,
    S_CP_WR,
    S_DONE
  } state_e;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned CountW = 9;
  localparam logic [5:0]  AlignRst = 6'd7;

endpackage

[rtl/core/pit_in_if.sv]
interface pit_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] key_addr;
  logic [63:0] item_value;
  logic [63:0] src_addr;
  logic [63:0] range_size;

  modport source (output valid, cmd, key_addr, item_value, src_addr, range_size,
                  input ready);
  modport sink   (input valid, cmd, key_addr, item_value, src_addr, range_size,
                  output ready);
endinterface

[rtl/core/pit_out_if.sv]
interface pit_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [2:0] status;
  logic [8:0] entry_count;

  modport source (output valid, ok, status, entry_count, input ready);
  modport sink   (input valid, ok, status, entry_count, output ready);
endinterface

[rtl/core/pit_cfg_if.sv]
interface pit_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] align_mask;

  modport source (output valid, align_mask, input ready);
  modport sink   (input valid, align_mask, output ready);
endinterface

[rtl/core/pointer_integrity_table_unit.sv]
// Channel  Dir  Beat contents
// in_i     in   cmd, key_addr, item_value, src_addr, range_size
// out_o    out  ok, status, entry_count
// cfg_i    in   align_mask (always ready)
//
// A command that reaches the table passes through setup (S_PRE, S_EVAL), a scan
// over the key/value memory read port (S_SCAN), a finish state (S_FIN) and a
// result state (S_DONE). Misaligned, no-op, overflow, overlap and reserved
// commands skip the scan and go from setup straight to the result state.
// copy_block adds a read and a write state per copied entry, and the write state
// repeats per occupied slot skipped while placing copies. No item is accepted
// during that work. Reset clears the valid bits and the count at once; no
// clearing pass. A result waiting on out_o holds the sequencer in its last state.
module pointer_integrity_table_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input logic   clk_i,
  input logic   rst_ni,
  pit_in_if.sink    in_i,
  pit_out_if.source out_o,
  pit_cfg_if.sink   cfg_i
);
  import pit_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  // command registers
  logic [2:0]  cmd_q;
  logic [63:0] key_q, val_q, src_q, sz_q;
  logic [5:0]  align_q;
  logic [64:0] dst_sum_q, src_sum_q;
  logic [63:0] delta_q;
  status_e     st_q, st_d;

  // table state
  logic [CAPACITY-1:0] valid_q, valid_d, mark_q, mark_d;
  logic [CW-1:0]       live_q, live_d;

  // scan state
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cv_q, cv_d;
  logic [IW-1:0] cidx_q, cidx_d;
  logic          found_q, found_d, free_q, free_d;
  logic [IW-1:0] midx_q, midx_d, fidx_q, fidx_d;
  logic [63:0]   mval_q, mval_d;
  logic [CW-1:0] ncopy_q, ncopy_d, removed_q, removed_d;
  logic [CW-1:0] ci_q, ci_d;
  logic [IW-1:0] fp_q, fp_d;

  // memories
  logic [63:0] key_mem [CAPACITY];
  logic [63:0] val_mem [CAPACITY];
  logic [63:0] sk_mem  [CAPACITY];
  logic [63:0] sv_mem  [CAPACITY];
  logic [63:0] rd_key_q, rd_val_q, sk_rd_q, sv_rd_q;
  logic          kwr_en, vwr_en, swr_en;
  logic [IW-1:0] kwr_addr, vwr_addr, swr_addr;
  logic [63:0]   kwr_data, vwr_data;

  // output register
  logic       out_v_q, out_load;
  logic [2:0] out_st_q;
  logic [8:0] out_cnt_q;

  logic        in_dst, in_src, hit, ent_v;
  logic [63:0] reloc;
  logic [CW:0] cp_total;

  pit_range_cmp u_cmp (
    .key_i    (rd_key_q),
    .dst_lo_i (key_q),
    .dst_hi_i (dst_sum_q[63:0]),
    .src_lo_i (src_q),
    .src_hi_i (src_sum_q[63:0]),
    .delta_i  (delta_q),
    .in_dst_o (in_dst),
    .in_src_o (in_src),
    .reloc_o  (reloc)
  );

  assign ent_v    = valid_q[cidx_q];
  assign hit      = ent_v && (rd_key_q == key_q);
  assign cp_total = {1'b0, live_q} - {1'b0, removed_q} + {1'b0, ncopy_q};

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_PRE;
      S_PRE:   state_d = S_EVAL;
      S_EVAL: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_DEFINE:
            if ((key_q[5:0] & align_q) == 6'd0) state_d = S_SCAN;
          CMD_CHECK, CMD_INVAL, CMD_CHECK_INV: state_d = S_SCAN;
          CMD_INVAL_BLK:
            if (key_q != '0 && sz_q != '0 && !dst_sum_q[64]) state_d = S_SCAN;
          CMD_COPY_BLK:
            if (key_q != src_q && sz_q != '0 && !dst_sum_q[64] && !src_sum_q[64])
              state_d = S_SCAN;
          CMD_MOVE_BLK:
            if (key_q != '0 && key_q != src_q && sz_q != '0 && !dst_sum_q[64] &&
                !src_sum_q[64] &&
                !(src_q < dst_sum_q[63:0] && src_sum_q[63:0] > key_q))
              state_d = S_SCAN;
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN:  if (cnt_q == CW'(CAPACITY) && !cv_q) state_d = S_FIN;
      S_FIN: begin
        state_d = S_DONE;
        if (cmd_q == CMD_COPY_BLK && cp_total <= (CW+1)'(CAPACITY) &&
            ncopy_q != '0)
          state_d = S_CP_RD;
      end
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR:
        if (!valid_q[fp_q]) state_d = (ci_q + 1'b1 == ncopy_q) ? S_DONE : S_CP_RD;
      S_DONE:  if (!out_v_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    st_d = st_q; valid_d = valid_q; mark_d = mark_q; live_d = live_q;
    cnt_d = cnt_q; cv_d = 1'b0; cidx_d = cidx_q;
    found_d = found_q; free_d = free_q; midx_d = midx_q; fidx_d = fidx_q;
    mval_d = mval_q; ncopy_d = ncopy_q; removed_d = removed_q;
    ci_d = ci_q; fp_d = fp_q;
    kwr_en = 1'b0; kwr_addr = cidx_q; kwr_data = reloc;
    vwr_en = 1'b0; vwr_addr = cidx_q; vwr_data = val_q;
    swr_en = 1'b0; swr_addr = ncopy_q[IW-1:0];
    out_load = 1'b0;
    case (state_q)
      S_EVAL: begin
        cnt_d = '0; found_d = 1'b0; free_d = 1'b0;
        ncopy_d = '0; removed_d = '0; mark_d = '0;
        st_d = STS_OK;
        case (cmd_q)
          CMD_DEFINE:
            if ((key_q[5:0] & align_q) != 6'd0) st_d = STS_MISALIGNED;
          CMD_INVAL_BLK:
            if (key_q != '0 && sz_q != '0 && dst_sum_q[64]) st_d = STS_OVERFLOW;
          CMD_COPY_BLK:
            if (key_q != src_q && sz_q != '0 && (dst_sum_q[64] || src_sum_q[64]))
              st_d = STS_OVERFLOW;
          CMD_MOVE_BLK:
            if (key_q != '0 && key_q != src_q && sz_q != '0) begin
              if (dst_sum_q[64] || src_sum_q[64]) st_d = STS_OVERFLOW;
              else if (src_q < dst_sum_q[63:0] && src_sum_q[63:0] > key_q)
                st_d = STS_OVERLAP;
            end
          CMD_CHECK, CMD_INVAL, CMD_CHECK_INV: st_d = STS_OK;
          default: st_d = STS_UNKNOWN;
        endcase
      end
      S_SCAN: begin
        // issue side
        if (cnt_q != CW'(CAPACITY)) begin
          cnt_d = cnt_q + 1'b1;
          cv_d = 1'b1;
          cidx_d = cnt_q[IW-1:0];
        end
        // compare side, one entry behind
        if (cv_q) begin
          case (cmd_q)
            CMD_DEFINE, CMD_CHECK, CMD_INVAL, CMD_CHECK_INV: begin
              if (!found_q && hit) begin
                found_d = 1'b1; midx_d = cidx_q; mval_d = rd_val_q;
              end
              if (!free_q && !ent_v) begin
                free_d = 1'b1; fidx_d = cidx_q;
              end
            end
            CMD_INVAL_BLK:
              if (ent_v && in_dst) begin
                valid_d[cidx_q] = 1'b0; live_d = live_q - 1'b1;
              end
            CMD_MOVE_BLK:
              if (ent_v && in_dst) begin
                valid_d[cidx_q] = 1'b0; live_d = live_q - 1'b1;
              end else if (ent_v && in_src) begin
                kwr_en = 1'b1;
              end
            CMD_COPY_BLK: begin
              if (ent_v && in_dst) begin
                mark_d[cidx_q] = 1'b1; removed_d = removed_q + 1'b1;
              end
              if (ent_v && in_src) begin
                swr_en = 1'b1; ncopy_d = ncopy_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        case (cmd_q)
          CMD_DEFINE:
            if (found_q) begin
              vwr_en = 1'b1; vwr_addr = midx_q;
            end else if (free_q) begin
              kwr_en = 1'b1; kwr_addr = fidx_q; kwr_data = key_q;
              vwr_en = 1'b1; vwr_addr = fidx_q;
              valid_d[fidx_q] = 1'b1; live_d = live_q + 1'b1;
            end else begin
              st_d = STS_FULL;
            end
          CMD_CHECK:
            if (!found_q) st_d = STS_MISSING;
            else if (mval_q != val_q) st_d = STS_MISMATCH;
          CMD_INVAL:
            if (found_q) begin
              valid_d[midx_q] = 1'b0; live_d = live_q - 1'b1;
            end
          CMD_CHECK_INV:
            if (!found_q) begin
              st_d = STS_MISSING;
            end else begin
              valid_d[midx_q] = 1'b0; live_d = live_q - 1'b1;
              if (mval_q != val_q) st_d = STS_MISMATCH;
            end
          CMD_COPY_BLK:
            if (cp_total > (CW+1)'(CAPACITY)) begin
              st_d = STS_FULL;
            end else begin
              valid_d = valid_q & ~mark_q;
              live_d = live_q - removed_q;
              ci_d = '0; fp_d = '0;
            end
          default: ;
        endcase
      end
      S_CP_WR: begin
        // walk to the lowest free slot, then place one copy
        if (valid_q[fp_q]) begin
          fp_d = fp_q + 1'b1;
        end else begin
          kwr_en = 1'b1; kwr_addr = fp_q; kwr_data = sk_rd_q;
          vwr_en = 1'b1; vwr_addr = fp_q; vwr_data = sv_rd_q;
          valid_d[fp_q] = 1'b1; live_d = live_q + 1'b1;
          ci_d = ci_q + 1'b1; fp_d = fp_q + 1'b1;
        end
      end
      S_DONE: out_load = !out_v_q || out_o.ready;
      default: ;
    endcase
  end

  // key/value memory and copy buffer
  always_ff @(posedge clk_i) begin
    if (kwr_en) key_mem[kwr_addr] <= kwr_data;
    if (vwr_en) val_mem[vwr_addr] <= vwr_data;
    if (swr_en) begin
      sk_mem[swr_addr] <= reloc;
      sv_mem[swr_addr] <= rd_val_q;
    end
    rd_key_q <= key_mem[cnt_q[IW-1:0]];
    rd_val_q <= val_mem[cnt_q[IW-1:0]];
    sk_rd_q  <= sk_mem[ci_q[IW-1:0]];
    sv_rd_q  <= sv_mem[ci_q[IW-1:0]];
  end

  // command payload and range setup
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.cmd;
      key_q <= in_i.key_addr;
      val_q <= in_i.item_value;
      src_q <= in_i.src_addr;
      sz_q  <= in_i.range_size;
    end
    if (state_q == S_PRE) begin
      dst_sum_q <= {1'b0, key_q} + {1'b0, sz_q};
      src_sum_q <= {1'b0, src_q} + {1'b0, sz_q};
      delta_q   <= key_q - src_q;
    end
    cidx_q <= cidx_d; midx_q <= midx_d; fidx_q <= fidx_d; mval_q <= mval_d;
    mark_q <= mark_d;
    if (out_load) begin
      out_st_q  <= st_q;
      out_cnt_q <= 9'(live_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      align_q <= AlignRst;
      valid_q <= '0;
      live_q <= '0;
      st_q <= STS_OK;
      cnt_q <= '0; cv_q <= 1'b0;
      found_q <= 1'b0; free_q <= 1'b0;
      ncopy_q <= '0; removed_q <= '0; ci_q <= '0; fp_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) align_q <= cfg_i.align_mask;
      valid_q <= valid_d;
      live_q <= live_d;
      st_q <= st_d;
      cnt_q <= cnt_d; cv_q <= cv_d;
      found_q <= found_d; free_q <= free_d;
      ncopy_q <= ncopy_d; removed_q <= removed_d; ci_q <= ci_d; fp_q <= fp_d;
      out_v_q <= (out_v_q && !out_o.ready) || out_load;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.status      = out_st_q;
  assign out_o.ok          = (out_st_q == STS_OK);
  assign out_o.entry_count = out_cnt_q;

  // live count tracks the valid bits whenever no command is at work
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (32'(live_q) == $countones(valid_q)))
    else $error("live count differs from valid bits");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(CAPACITY))
    else $error("live count above capacity");

  // a result is produced only after a command was taken
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == S_DONE))
    else $error("result loaded outside done state");

  // placing copies never runs off the end of the table
  a_cpfree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CP_RD) |-> (live_q < CW'(CAPACITY)))
    else $error("copy placement with full table");

endmodule

[rtl/core/pit_range_cmp.sv]
// Shared range test and key relocation used by every scan step
module pit_range_cmp (
  input  logic [63:0] key_i,
  input  logic [63:0] dst_lo_i,
  input  logic [63:0] dst_hi_i,
  input  logic [63:0] src_lo_i,
  input  logic [63:0] src_hi_i,
  input  logic [63:0] delta_i,
  output logic        in_dst_o,
  output logic        in_src_o,
  output logic [63:0] reloc_o
);

  // half-open ranges, ends known not to wrap
  assign in_dst_o = (key_i >= dst_lo_i) && (key_i < dst_hi_i);
  assign in_src_o = (key_i >= src_lo_i) && (key_i < src_hi_i);
  assign reloc_o  = key_i + delta_i;

endmodule

[tb/pit_tb_pkg.sv]
`timescale 1ns / 100ps
package pit_tb_pkg;
  import pit_pkg::*;

  // One command beat
  typedef struct {
    cmd_e        cmd;
    logic [63:0] key_addr;
    logic [63:0] item_value;
    logic [63:0] src_addr;
    logic [63:0] range_size;
  } pit_cmd_t;

  // One result beat
  typedef struct {
    logic       ok;
    status_e    status;
    logic [8:0] entry_count;
  } pit_res_t;
endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import pit_pkg::*;
  import pit_tb_pkg::*;

  localparam int Cap = 256;
  // one command: setup, scan, finish, result, plus copy placement
  localparam int CmdCycles = 3 + Cap + 1 + 1 + 1 + 3 * Cap;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pit_in_if  in_if();
  pit_out_if out_if();
  pit_cfg_if cfg_if();

  pointer_integrity_table_unit #(.CAPACITY(Cap)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // table shadow
  logic [63:0] tbl_key [Cap];
  logic [63:0] tbl_val [Cap];
  bit          tbl_vld [Cap];
  int unsigned tbl_live;
  logic [5:0]  shadow_mask;

  pit_cmd_t pending_cmds[$];
  pit_res_t expected_results[$];
  int       fail_cnt = 0;
  int       sent_cnt = 0;
  bit       drive_en = 1'b0;

  // keys drawn from a small pool so that commands hit each other
  logic [63:0] key_pool[16];

  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < Cap; i++)
      if (tbl_vld[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < Cap; i++)
      if (!tbl_vld[i]) return i;
    return -1;
  endfunction

  function automatic bit in_span(logic [63:0] k, logic [63:0] st, logic [63:0] sz);
    return k >= st && (k - st) < sz;
  endfunction

  function automatic bit wraps(logic [63:0] st, logic [63:0] sz);
    logic [64:0] e;
    e = {1'b0, st} + {1'b0, sz};
    return e[64];
  endfunction

  function automatic void erase_span(logic [63:0] st, logic [63:0] sz);
    for (int i = 0; i < Cap; i++)
      if (tbl_vld[i] && in_span(tbl_key[i], st, sz)) begin
        tbl_vld[i] = 1'b0;
        tbl_live--;
      end
  endfunction

  // Apply one command to the shadow table and return its status
  function automatic status_e apply_cmd(pit_cmd_t c);
    int i;
    int n;
    int removed;
    logic [63:0] ck[$];
    logic [63:0] cv[$];
    logic [63:0] k;
    logic [63:0] s;
    logic [63:0] z;
    k = c.key_addr;
    s = c.src_addr;
    z = c.range_size;
    case (c.cmd)
      CMD_DEFINE: begin
        if ((k & {58'd0, shadow_mask}) != 0) return STS_MISALIGNED;
        i = find_key(k);
        if (i < 0) begin
          i = find_free();
          if (i < 0) return STS_FULL;
          tbl_vld[i] = 1'b1;
          tbl_key[i] = k;
          tbl_live++;
        end
        tbl_val[i] = c.item_value;
        return STS_OK;
      end
      CMD_CHECK, CMD_CHECK_INV: begin
        i = find_key(k);
        if (i < 0) return STS_MISSING;
        if (c.cmd == CMD_CHECK_INV) begin
          tbl_vld[i] = 1'b0;
          tbl_live--;
        end
        return (tbl_val[i] == c.item_value) ? STS_OK : STS_MISMATCH;
      end
      CMD_INVAL: begin
        i = find_key(k);
        if (i >= 0) begin
          tbl_vld[i] = 1'b0;
          tbl_live--;
        end
        return STS_OK;
      end
      CMD_INVAL_BLK: begin
        if (k == 0 || z == 0) return STS_OK;
        if (wraps(k, z)) return STS_OVERFLOW;
        erase_span(k, z);
        return STS_OK;
      end
      CMD_COPY_BLK: begin
        if (k == s || z == 0) return STS_OK;
        if (wraps(k, z) || wraps(s, z)) return STS_OVERFLOW;
        removed = 0;
        for (i = 0; i < Cap; i++)
          if (tbl_vld[i] && in_span(tbl_key[i], k, z)) removed++;
        for (i = 0; i < Cap; i++)
          if (tbl_vld[i] && in_span(tbl_key[i], s, z)) begin
            ck.push_back(tbl_key[i] - s + k);
            cv.push_back(tbl_val[i]);
          end
        if (tbl_live - removed + ck.size() > Cap) return STS_FULL;
        erase_span(k, z);
        for (n = 0; n < ck.size(); n++) begin
          i = find_free();
          if (i < 0) break;
          tbl_vld[i] = 1'b1;
          tbl_key[i] = ck[n];
          tbl_val[i] = cv[n];
          tbl_live++;
        end
        return STS_OK;
      end
      CMD_MOVE_BLK: begin
        if (k == 0 || k == s || z == 0) return STS_OK;
        if (wraps(k, z) || wraps(s, z)) return STS_OVERFLOW;
        if (s < k + z && s + z > k) return STS_OVERLAP;
        erase_span(k, z);
        for (i = 0; i < Cap; i++)
          if (tbl_vld[i] && in_span(tbl_key[i], s, z))
            tbl_key[i] = tbl_key[i] - s + k;
        return STS_OK;
      end
      default: return STS_UNKNOWN;
    endcase
  endfunction

  function automatic pit_cmd_t make_cmd(cmd_e op, logic [63:0] k, logic [63:0] v,
                                        logic [63:0] s, logic [63:0] z);
    pit_cmd_t c;
    c.cmd = op;
    c.key_addr = k;
    c.item_value = v;
    c.src_addr = s;
    c.range_size = z;
    return c;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) == 0) return rand64();
    return key_pool[$urandom_range(0, 15)];
  endfunction

  // Random command, weighted toward the single-entry ones
  function automatic pit_cmd_t rand_cmd();
    int w;
    logic [63:0] base;
    logic [63:0] z;
    w = $urandom_range(0, 99);
    base = key_pool[$urandom_range(0, 15)] & ~64'hFFF;
    z = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 4096));
    if (w < 35) return make_cmd(CMD_DEFINE, pick_key(), rand64(), rand64(), rand64());
    if (w < 55) return make_cmd(CMD_CHECK, pick_key(),
                                ($urandom_range(0, 1) != 0) ? rand64() : 64'd0,
                                rand64(), rand64());
    if (w < 63) return make_cmd(CMD_INVAL, pick_key(), rand64(), rand64(), rand64());
    if (w < 73) return make_cmd(CMD_CHECK_INV, pick_key(), rand64(), rand64(), rand64());
    if (w < 79) return make_cmd(CMD_INVAL_BLK, base, rand64(), rand64(), z);
    if (w < 88) return make_cmd(CMD_COPY_BLK, base ^ 64'h1_0000, rand64(),
                                key_pool[$urandom_range(0, 15)] & ~64'hFFF, z);
    if (w < 97) return make_cmd(CMD_MOVE_BLK, base ^ 64'h2_0000, rand64(),
                                key_pool[$urandom_range(0, 15)] & ~64'hFFF, z);
    return make_cmd(CMD_RESERVED, rand64(), rand64(), rand64(), rand64());
  endfunction

  // Driver: bursts with random gaps; inputs change on the falling edge
  int gap_left = 0;
  int burst_left = 0;
  bit in_taken = 1'b0;

  // remember whether the last rising edge took a beat
  always @(posedge clk_i) in_taken <= in_if.valid && in_if.ready;

  always @(negedge clk_i) begin
    if (in_taken) begin
      pending_cmds.pop_front();
      sent_cnt++;
    end
    if (!drive_en || pending_cmds.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      in_if.valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else begin
      in_if.valid      <= 1'b1;
      in_if.cmd        <= pending_cmds[0].cmd;
      in_if.key_addr   <= pending_cmds[0].key_addr;
      in_if.item_value <= pending_cmds[0].item_value;
      in_if.src_addr   <= pending_cmds[0].src_addr;
      in_if.range_size <= pending_cmds[0].range_size;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      end
    end
  end

  // Receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_phase < 40) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: predict on accepted commands, check on accepted results
  always @(posedge clk_i) begin
    pit_cmd_t c;
    pit_res_t r;
    pit_res_t e;
    if (rst_ni && in_if.valid && in_if.ready) begin
      c.cmd = cmd_e'(in_if.cmd);
      c.key_addr = in_if.key_addr;
      c.item_value = in_if.item_value;
      c.src_addr = in_if.src_addr;
      c.range_size = in_if.range_size;
      e.status = apply_cmd(c);
      e.ok = (e.status == STS_OK);
      e.entry_count = tbl_live[8:0];
      expected_results.push_back(e);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.ok = out_if.ok;
      r.status = status_e'(out_if.status);
      r.entry_count = out_if.entry_count;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0d status=%0d count=%0d",
                 $time, r.ok, r.status, r.entry_count);
        fail_cnt++;
      end else begin
        e = expected_results.pop_front();
        if (r.ok !== e.ok || r.status !== e.status || r.entry_count !== e.entry_count) begin
          $display("%0t: result mismatch expected ok=%0d status=%0d count=%0d",
                   $time, e.ok, e.status, e.entry_count);
          $display("%0t:                 actual   ok=%0d status=%0d count=%0d",
                   $time, r.ok, r.status, r.entry_count);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_mask(logic [5:0] m);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.align_mask <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    shadow_mask = m;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [5:0] masks[5];
    int target;
    masks = '{6'd0, 6'd63, 6'd1, 6'd15, 6'd7};
    in_if.valid = 1'b0;
    in_if.cmd = CMD_DEFINE;
    in_if.key_addr = '0;
    in_if.item_value = '0;
    in_if.src_addr = '0;
    in_if.range_size = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.align_mask = '0;
    shadow_mask = AlignRst;
    tbl_live = 0;
    for (int i = 0; i < Cap; i++) tbl_vld[i] = 1'b0;
    for (int i = 0; i < 16; i++)
      key_pool[i] = 64'h7F00_0000_0000 + 64'(i * 8) + (($urandom_range(0, 3) == 0) ? 1 : 0);
    key_pool[15] = 64'hFFFF_FFFF_FFFF_FFC0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    drive_en = 1'b1;

    // directed: every command and edge case, reset mask
    pending_cmds.push_back(make_cmd(CMD_DEFINE, 64'h1000, '1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DEFINE, 64'h1003, 64'h5, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DEFINE, 64'h1000, 64'h0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DEFINE, 64'hFFFF_FFFF_FFFF_FFF8, 64'hA5A5, '1, '1));
    pending_cmds.push_back(make_cmd(CMD_CHECK, 64'h1000, 64'h0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CHECK, 64'h1000, 64'h1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CHECK, 64'h2000, 64'h0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_INVAL, 64'h2000, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DEFINE, 64'h1008, 64'h77, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_COPY_BLK, 64'h1000, 64'h1000, 0, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_COPY_BLK, 64'h3000, 0, 64'h1000, 0));
    pending_cmds.push_back(make_cmd(CMD_COPY_BLK, 64'h3000, 0, 64'h1000, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_COPY_BLK, 64'h3000, 0, 64'h1000, '1));
    pending_cmds.push_back(make_cmd(CMD_MOVE_BLK, 64'h3008, 0, 64'h3000, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_MOVE_BLK, 0, 0, 64'h3000, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_MOVE_BLK, 64'h5000, 0, 64'h3000, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_MOVE_BLK, 64'h5000, 0, '1, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_CHECK_INV, 64'h5008, 64'h0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CHECK_INV, 64'h5000, 64'h0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_INVAL_BLK, 0, 0, 0, 64'h100));
    pending_cmds.push_back(make_cmd(CMD_INVAL_BLK, 64'h1000, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_INVAL_BLK, 64'hFFFF_FFFF_FFFF_FFF8, 0, 0, 64'h8));
    pending_cmds.push_back(make_cmd(CMD_INVAL_BLK, 64'h1000, 0, 0, 64'h10));
    pending_cmds.push_back(make_cmd(CMD_RESERVED, '1, '1, '1, '1));
    wait_drained();

    // fill the table to capacity, then overflow define and copy
    write_mask(6'd0);
    for (int i = 0; i <= Cap; i++)
      pending_cmds.push_back(make_cmd(CMD_DEFINE, 64'h8_0000 + 64'(i), 64'(i), 0, 0));
    pending_cmds.push_back(make_cmd(CMD_COPY_BLK, 64'h9_0000, 0, 64'h8_0000, 64'h4));
    pending_cmds.push_back(make_cmd(CMD_INVAL_BLK, 64'h8_0000, 0, 0, 64'h200));
    wait_drained();

    // random phases across mask settings
    target = 1500 / 5;
    foreach (masks[m]) begin
      write_mask(masks[m]);
      for (int i = 0; i < target; i++) pending_cmds.push_back(rand_cmd());
      wait_drained();
    end
    repeat (CmdCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd20_000_000_0);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
